// File: rtl/core/mwpm_pkg.sv
`timescale 1ns / 1ps
package mwpm_pkg;

  localparam int CordicSteps = 30;
  localparam int CordicW     = 34;
  localparam int WheelW      = 46;
  localparam int MagW        = 45;
  localparam int DivSteps    = 8;

  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_MIN_PWM  = 2'd2;
  localparam logic [1:0] CFG_MAX_PWM  = 2'd3;

  typedef logic signed [CordicW-1:0] cval_t;

  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/mwpm_cordic.sv
`timescale 1ns / 1ps
// Pipelined rotation CORDIC, one iteration per stage, plus a sideband that
// rides along with each beat. Outputs are Q15 cosine and sine.
module mwpm_cordic
  import mwpm_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int SideW      = 58
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [15:0]               in_angle,
  input  logic [SideW-1:0]          in_side,
  output logic                      out_vld,
  output logic signed [17:0]        out_cos,
  output logic signed [17:0]        out_sin,
  output logic [SideW-1:0]          out_side
);

  localparam int N = CordicSteps;

  logic               vld_r  [N+1];
  cval_t              x_r    [N+1];
  cval_t              y_r    [N+1];
  logic signed [32:0] z_r    [N+1];
  logic               flip_r [N+1];
  logic [SideW-1:0]   side_r [N+1];

  logic [31:0] ang;
  logic [1:0]  quad;
  logic        flip0;
  logic [31:0] ang_adj;

  always_comb begin
    ang  = {in_angle, 16'd0} & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    quad = ang[31:30];
    flip0 = (quad == 2'd1) || (quad == 2'd2);
    ang_adj = flip0 ? (ang + 32'h80000000) : ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
    if (adv) begin
      x_r[0]    <= cval_t'(652032874);
      y_r[0]    <= '0;
      z_r[0]    <= {ang_adj[31], ang_adj};
      flip_r[0] <= flip0;
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    cval_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (adv) begin
        if (!z_r[i][32]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - $signed({1'b0, atan_lut(i)});
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + $signed({1'b0, atan_lut(i)});
        end
        flip_r[i+1] <= flip_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  cval_t xf, yf, xr, yr;
  always_comb begin
    xf = flip_r[N] ? -x_r[N] : x_r[N];
    yf = flip_r[N] ? -y_r[N] : y_r[N];
    xr = (xf + cval_t'(16384)) >>> 15;
    yr = (yf + cval_t'(16384)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld_r[N];
    end
    if (adv) begin
      out_cos  <= xr[17:0];
      out_sin  <= yr[17:0];
      out_side <= side_r[N];
    end
  end

endmodule

// File: rtl/core/mwpm_wheels.sv
`timescale 1ns / 1ps
// Rotates the velocity, forms the four wheel speeds and their magnitudes,
// then the largest magnitude. Four register stages.
module mwpm_wheels
  import mwpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic signed [17:0]       in_cos,
  input  logic signed [17:0]       in_sin,
  input  logic signed [15:0]       in_turn,
  input  logic signed [15:0]       in_vx,
  input  logic signed [15:0]       in_vy,
  input  logic [10:0]              in_lever,
  input  logic [7:0]               in_min,
  input  logic [7:0]               in_max,
  output logic                     out_vld,
  output logic [MagW-1:0]          out_mag [4],
  output logic [3:0]               out_pos,
  output logic [MagW-1:0]          out_peak,
  output logic [7:0]               out_min,
  output logic [7:0]               out_max
);

  // Stage A: four products and the lever term.
  logic               a_vld_r;
  logic signed [33:0] a_cx_r, a_sy_r, a_cy_r, a_sx_r;
  logic signed [27:0] a_lt_r;
  logic [7:0]         a_min_r, a_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_vld;
    if (adv) begin
      a_cx_r  <= 34'(in_cos * in_vx);
      a_sy_r  <= 34'(in_sin * in_vy);
      a_cy_r  <= 34'(in_cos * in_vy);
      a_sx_r  <= 34'(in_sin * in_vx);
      a_lt_r  <= 28'($signed({1'b0, in_lever}) * in_turn);
      a_min_r <= in_min;
      a_max_r <= in_max;
    end
  end

  // Stage B: rotated sums, times 1000, lever term shifted into place.
  logic               b_vld_r;
  logic signed [45:0] b_p_r, b_m_r, b_lt_r;
  logic [7:0]         b_min_r, b_max_r;
  logic signed [35:0] rsum, rdif;

  always_comb begin
    rsum = 36'(a_cx_r) + 36'(a_sy_r) + 36'(a_cy_r) - 36'(a_sx_r);
    rdif = 36'(a_cx_r) + 36'(a_sy_r) - 36'(a_cy_r) + 36'(a_sx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= a_vld_r;
    if (adv) begin
      b_p_r   <= 46'(rsum * $signed(11'sd1000));
      b_m_r   <= 46'(rdif * $signed(11'sd1000));
      b_lt_r  <= 46'(a_lt_r) <<< 15;
      b_min_r <= a_min_r;
      b_max_r <= a_max_r;
    end
  end

  // Stage C: wheel speeds and magnitudes.
  logic               c_vld_r;
  logic [MagW-1:0]    c_mag_r [4];
  logic [3:0]         c_pos_r;
  logic [7:0]         c_min_r, c_max_r;
  logic signed [WheelW-1:0] w [4];

  always_comb begin
    w[0] = b_lt_r + b_p_r;
    w[1] = b_m_r - b_lt_r;
    w[2] = b_lt_r + b_m_r;
    w[3] = b_p_r - b_lt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= b_vld_r;
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        c_mag_r[k] <= w[k][WheelW-1] ? MagW'(-w[k]) : MagW'(w[k]);
        c_pos_r[k] <= !w[k][WheelW-1] && (w[k] != '0);
      end
      c_min_r <= b_min_r;
      c_max_r <= b_max_r;
    end
  end

  // Stage D: largest magnitude.
  logic [MagW-1:0] m01, m23;
  always_comb begin
    m01 = (c_mag_r[0] > c_mag_r[1]) ? c_mag_r[0] : c_mag_r[1];
    m23 = (c_mag_r[2] > c_mag_r[3]) ? c_mag_r[2] : c_mag_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld <= 1'b0;
    else if (adv) out_vld <= c_vld_r;
    if (adv) begin
      out_mag  <= c_mag_r;
      out_pos  <= c_pos_r;
      out_peak <= (m01 > m23) ? m01 : m23;
      out_min  <= c_min_r;
      out_max  <= c_max_r;
    end
  end

endmodule

// File: rtl/core/mwpm_duty.sv
`timescale 1ns / 1ps
// Duty mapping. The quotient mag*span/peak is below 256, so it is found
// one bit per stage by restoring division, eight stages, four lanes.
module mwpm_duty
  import mwpm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [MagW-1:0] in_mag [4],
  input  logic [3:0]      in_pos,
  input  logic [MagW-1:0] in_peak,
  input  logic [7:0]      in_min,
  input  logic [7:0]      in_max,
  output logic            out_vld,
  output logic [7:0]      out_duty [4],
  output logic [3:0]      out_fwd
);

  localparam int NumW = MagW + 8;

  // Stage 0: numerators; a falling map divides with a ceiling, so the
  // numerator is biased by peak-1.
  logic            s_vld_r [DivSteps+1];
  logic [NumW-1:0] s_rem_r [DivSteps+1][4];
  logic [7:0]      s_q_r   [DivSteps+1][4];
  logic [3:0]      s_nz_r  [DivSteps+1];
  logic [3:0]      s_pos_r [DivSteps+1];
  logic [MagW-1:0] s_peak_r[DivSteps+1];
  logic [7:0]      s_min_r [DivSteps+1];
  logic            s_fall_r[DivSteps+1];

  logic       fall;
  logic [7:0] span;
  assign fall = in_max < in_min;
  assign span = fall ? (in_min - in_max) : (in_max - in_min);

  always_ff @(posedge clk) begin
    if (!rst_n) s_vld_r[0] <= 1'b0;
    else if (adv) s_vld_r[0] <= in_vld;
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s_rem_r[0][k] <= NumW'(in_mag[k] * span)
                         + (fall ? NumW'(in_peak - MagW'(1)) : NumW'(0));
        s_q_r[0][k]   <= '0;
        s_nz_r[0][k]  <= in_mag[k] != '0;
      end
      s_pos_r[0]  <= in_pos;
      s_peak_r[0] <= in_peak;
      s_min_r[0]  <= in_min;
      s_fall_r[0] <= fall;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Sh = DivSteps - 1 - j;
    logic [NumW-1:0] d;
    assign d = NumW'(s_peak_r[j]) << Sh;
    always_ff @(posedge clk) begin
      if (!rst_n) s_vld_r[j+1] <= 1'b0;
      else if (adv) s_vld_r[j+1] <= s_vld_r[j];
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          if (s_rem_r[j][k] >= d) begin
            s_rem_r[j+1][k] <= s_rem_r[j][k] - d;
            s_q_r[j+1][k]   <= s_q_r[j][k] | (8'd1 << Sh);
          end else begin
            s_rem_r[j+1][k] <= s_rem_r[j][k];
            s_q_r[j+1][k]   <= s_q_r[j][k];
          end
        end
        s_nz_r[j+1]   <= s_nz_r[j];
        s_pos_r[j+1]  <= s_pos_r[j];
        s_peak_r[j+1] <= s_peak_r[j];
        s_min_r[j+1]  <= s_min_r[j];
        s_fall_r[j+1] <= s_fall_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld <= 1'b0;
    else if (adv) out_vld <= s_vld_r[DivSteps];
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if (!s_nz_r[DivSteps][k]) begin
          out_duty[k] <= '0;
          out_fwd[k]  <= 1'b0;
        end else begin
          out_duty[k] <= s_fall_r[DivSteps] ? (s_min_r[DivSteps] - s_q_r[DivSteps][k])
                                            : (s_min_r[DivSteps] + s_q_r[DivSteps][k]);
          out_fwd[k]  <= s_pos_r[DivSteps][k];
        end
      end
    end
  end

endmodule

// File: rtl/core/mecanum_wheel_pwm_mixer.sv
`timescale 1ns / 1ps
// Mecanum wheel mixer: turns a body command (turn rate, x/y velocity) and a
// heading into four wheel PWM duties with direction bits.
// Input channel in_*: one command per beat, accepted when in_valid is high
// and in_stall is low. Output channel out_*: one result per command, in
// order, taken when out_valid is high and out_stall is low.
// Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Write registers only while the pipe is
// empty. Indexes past the last register are ignored.
// Throughput is one command per cycle while the output is not stalled. The pipe
// is 46 registers deep: 31 CORDIC stages plus rounding, 4 wheel-mixing stages,
// and 10 stages for the duty mapping (numerator, eight bit-per-stage division
// steps, output).
// The whole pipeline advances as one when the output slot is free or empty;
// while out_stall holds a valid result, every stage holds and in_stall is
// high, so nothing is lost or repeated.
// Reset clears all valid bits and loads offsets 100/100 mm, min 160, max 255.
module mecanum_wheel_pwm_mixer
  import mwpm_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_turn_rate,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic [15:0]        in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_duty0,
  output logic               out_fwd0,
  output logic [7:0]         out_duty1,
  output logic               out_fwd1,
  output logic [7:0]         out_duty2,
  output logic               out_fwd2,
  output logic [7:0]         out_duty3,
  output logic               out_fwd3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  localparam int SideW = 48;

  logic [9:0] off_x_r, off_y_r;
  logic [7:0] min_pwm_r, max_pwm_r;
  logic       adv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r   <= 10'd100;
      off_y_r   <= 10'd100;
      min_pwm_r <= 8'd160;
      max_pwm_r <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET_X: off_x_r   <= cfg_data;
        CFG_OFFSET_Y: off_y_r   <= cfg_data;
        CFG_MIN_PWM:  min_pwm_r <= cfg_data[7:0];
        CFG_MAX_PWM:  max_pwm_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic              c_vld;
  logic signed [17:0] c_cos, c_sin;
  logic [SideW-1:0]  c_side;

  mwpm_cordic #(.ANGLE_BITS(ANGLE_BITS), .SideW(SideW)) u_cordic (
    .clk, .rst_n, .adv,
    .in_vld(in_valid), .in_angle(in_heading),
    .in_side({in_turn_rate, in_vel_x, in_vel_y}),
    .out_vld(c_vld), .out_cos(c_cos), .out_sin(c_sin), .out_side(c_side)
  );

  logic            w_vld;
  logic [MagW-1:0] w_mag [4];
  logic [3:0]      w_pos;
  logic [MagW-1:0] w_peak;
  logic [7:0]      w_min, w_max;

  mwpm_wheels u_wheels (
    .clk, .rst_n, .adv,
    .in_vld(c_vld), .in_cos(c_cos), .in_sin(c_sin),
    .in_turn(c_side[47:32]), .in_vx(c_side[31:16]), .in_vy(c_side[15:0]),
    .in_lever(11'(off_x_r) + 11'(off_y_r)),
    .in_min(min_pwm_r), .in_max(max_pwm_r),
    .out_vld(w_vld), .out_mag(w_mag), .out_pos(w_pos), .out_peak(w_peak),
    .out_min(w_min), .out_max(w_max)
  );

  logic [7:0] duty [4];
  logic [3:0] fwd;

  mwpm_duty u_duty (
    .clk, .rst_n, .adv,
    .in_vld(w_vld), .in_mag(w_mag), .in_pos(w_pos), .in_peak(w_peak),
    .in_min(w_min), .in_max(w_max),
    .out_vld(out_valid), .out_duty(duty), .out_fwd(fwd)
  );

  assign out_duty0 = duty[0];
  assign out_duty1 = duty[1];
  assign out_duty2 = duty[2];
  assign out_duty3 = duty[3];
  assign out_fwd0  = fwd[0];
  assign out_fwd1  = fwd[1];
  assign out_fwd2  = fwd[2];
  assign out_fwd3  = fwd[3];

endmodule
